// ===== src/faz_pkg.sv =====
// ----------------------------------------------------------------------------
// faz_pkg: shared types and constants for the all-zero filter
// Widths, op and register codes, and the structs passed along the tap chain.
// ----------------------------------------------------------------------------
package faz_pkg;

  localparam int MAX_ORDER      = 32;
  localparam int NUM_TAPS       = MAX_ORDER + 1;
  localparam int COEF_FRAC_BITS = 14;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 18;
  localparam int IDX_W          = 6;
  localparam int ORDER_W        = 6;
  localparam int OP_W           = 2;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  // 33 products of 34 bits need 6 more bits of headroom
  localparam int ACC_W          = PROD_W + 6;
  localparam int OUT_W          = 24;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 6;

  localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNITY_LEAD   = 1'd1;

  // Broadcast control to every tap cell
  typedef struct packed {
    logic                       shift;
    logic                       clear;
    logic                       coef_we;
    logic [IDX_W-1:0]           coef_idx;
    logic signed [COEF_W-1:0]   coef_val;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ORDER_W-1:0]         order;
    logic                       unity;
  } ctrl_t;

  // Partial sum travelling down the chain
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] acc;
  } pipe_t;

endpackage

// ===== src/fir_all_zero_filter.sv =====
// ----------------------------------------------------------------------------
// fir_all_zero_filter: configurable-order FIR filter on a tap-cell chain
// Input transactions filter a sample, write a coefficient or clear the
// delay line; filtered samples yield one rounded, saturated output each.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the operation in tuser and sample/coefficient in tdata.
//   m_axis returns one transaction per filtered sample, the clip flag in tuser.
//   cfg_we_i writes filter_order (index 0) or unity_lead (index 1); write only
//   while the block is idle.
// Sequencing:
//   A sample shifts the delay line when accepted; its partial sum then walks
//   the 33 tap cells, one cell per cycle, and passes the hold stage into the
//   output register, which drives m_axis. The next transaction is taken once
//   the sum has left the chain and the hold stage, so samples never overlap.
//   Coefficient writes and clears produce no output.
// Reset:
//   Coefficients and delay line clear to zero, order becomes 1, unity off.
// Stall:
//   A result waiting in the output register does not block the next input;
//   a second finished result waits in a hold stage until the first is taken.
// ----------------------------------------------------------------------------
module fir_all_zero_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] sample_in, [21:16] coef_index, [39:22] coef_value
  input  logic [39:0]                       s_axis_tdata,
  // [1:0] op
  input  logic [faz_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] sample_out
  output logic [23:0]                       m_axis_tdata,
  // [0] saturated
  output logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [faz_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [faz_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [faz_pkg::ORDER_W-1:0]         order_q, order_d;
  logic                                unity_q, unity_d;
  logic [faz_pkg::ORDER_W-1:0]         eff_order;
  logic                                start_q;
  logic                                accept;
  logic                                chain_busy;
  logic                                out_busy;
  faz_pkg::ctrl_t                      ctrl;
  faz_pkg::pipe_t                      pipe [0:faz_pkg::NUM_TAPS];
  logic signed [faz_pkg::SAMPLE_W-1:0] samples [0:faz_pkg::NUM_TAPS];
  logic signed [faz_pkg::OUT_W-1:0]    out_data;

  always_comb begin
    order_d = order_q;
    unity_d = unity_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        faz_pkg::REG_FILTER_ORDER: order_d = cfg_data_i[faz_pkg::ORDER_W-1:0];
        faz_pkg::REG_UNITY_LEAD:   unity_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // order 0 acts as 1, anything past the chain length as the full chain
  always_comb begin
    if (order_q == '0) begin
      eff_order = faz_pkg::ORDER_W'(1);
    end else if (order_q > faz_pkg::ORDER_W'(faz_pkg::MAX_ORDER)) begin
      eff_order = faz_pkg::ORDER_W'(faz_pkg::MAX_ORDER);
    end else begin
      eff_order = order_q;
    end
  end

  always_comb begin
    chain_busy = start_q;
    for (int k = 1; k <= faz_pkg::NUM_TAPS; k++) begin
      chain_busy = chain_busy | pipe[k].vld;
    end
  end

  assign s_axis_tready = !chain_busy && !out_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl.shift    = 1'b0;
    ctrl.clear    = 1'b0;
    ctrl.coef_we  = 1'b0;
    if (accept) begin
      unique case (s_axis_tuser)
        faz_pkg::OP_FILTER: ctrl.shift   = 1'b1;
        faz_pkg::OP_COEF:   ctrl.coef_we = 1'b1;
        faz_pkg::OP_CLEAR:  ctrl.clear   = 1'b1;
        default: ;
      endcase
    end
    ctrl.sample   = s_axis_tdata[15:0];
    ctrl.coef_idx = s_axis_tdata[21:16];
    ctrl.coef_val = s_axis_tdata[39:22];
    ctrl.order    = eff_order;
    ctrl.unity    = unity_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= faz_pkg::ORDER_W'(1);
      unity_q <= 1'b0;
      start_q <= 1'b0;
    end else begin
      order_q <= order_d;
      unity_q <= unity_d;
      start_q <= ctrl.shift;
    end
  end

  assign pipe[0].vld = start_q;
  assign pipe[0].acc = '0;
  assign samples[0]  = ctrl.sample;

  for (genvar k = 0; k < faz_pkg::NUM_TAPS; k++) begin : g_tap
    faz_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tap_idx_i     (faz_pkg::IDX_W'(k)),
      .ctrl_i        (ctrl),
      .prev_sample_i (samples[k]),
      .sample_o      (samples[k+1]),
      .pipe_i        (pipe[k]),
      .pipe_o        (pipe[k+1])
    );
  end

  faz_outstage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pipe_i     (pipe[faz_pkg::NUM_TAPS]),
    .busy_o     (out_busy),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_data_o (out_data),
    .out_sat_o  (m_axis_tuser)
  );

  assign m_axis_tdata = out_data;

endmodule

// ===== src/faz_cell.sv =====
// ----------------------------------------------------------------------------
// faz_cell: one filter tap
// Holds one coefficient and one delay-line sample, adds its term (product,
// tap-0 unity sample or zero) to the previous cell's sum, hands it onward.
// ----------------------------------------------------------------------------
module faz_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [faz_pkg::IDX_W-1:0]           tap_idx_i,
  input  faz_pkg::ctrl_t                      ctrl_i,
  input  logic signed [faz_pkg::SAMPLE_W-1:0] prev_sample_i,
  output logic signed [faz_pkg::SAMPLE_W-1:0] sample_o,
  input  faz_pkg::pipe_t                      pipe_i,
  output faz_pkg::pipe_t                      pipe_o
);

  logic signed [faz_pkg::COEF_W-1:0]   coef_q, coef_d;
  logic signed [faz_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic signed [faz_pkg::PROD_W-1:0]   prod;
  logic signed [faz_pkg::ACC_W-1:0]    term;
  logic                                vld_q;
  logic signed [faz_pkg::ACC_W-1:0]    acc_q, acc_d;

  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.coef_we && (ctrl_i.coef_idx == tap_idx_i)) begin
      coef_d = ctrl_i.coef_val;
    end
    sample_d = sample_q;
    if (ctrl_i.clear) begin
      sample_d = '0;
    end else if (ctrl_i.shift) begin
      sample_d = prev_sample_i;
    end
  end

  assign prod = coef_q * sample_q;

  always_comb begin
    if ((tap_idx_i == '0) && ctrl_i.unity) begin
      term = {{(faz_pkg::ACC_W - faz_pkg::SAMPLE_W - faz_pkg::COEF_FRAC_BITS){sample_q[
              faz_pkg::SAMPLE_W-1]}}, sample_q, {faz_pkg::COEF_FRAC_BITS{1'b0}}};
    end else if (tap_idx_i <= ctrl_i.order) begin
      term = faz_pkg::ACC_W'(prod);
    end else begin
      term = '0;
    end
    acc_d = pipe_i.acc + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      sample_q <= '0;
      vld_q    <= 1'b0;
    end else begin
      coef_q   <= coef_d;
      sample_q <= sample_d;
      vld_q    <= pipe_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.vld) begin
      acc_q <= acc_d;
    end
  end

  assign sample_o   = sample_q;
  assign pipe_o.vld = vld_q;
  assign pipe_o.acc = acc_q;

endmodule

// ===== src/faz_outstage.sv =====
// ----------------------------------------------------------------------------
// faz_outstage: round, saturate and present the filter result
// Catches the finished sum, rounds by the coefficient fraction, clips to the
// output width and holds it in the output register until taken.
// ----------------------------------------------------------------------------
module faz_outstage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  faz_pkg::pipe_t                   pipe_i,
  output logic                             busy_o,
  output logic                             out_vld_o,
  input  logic                             out_rdy_i,
  output logic signed [faz_pkg::OUT_W-1:0] out_data_o,
  output logic                             out_sat_o
);

  localparam int SHIFT_W = faz_pkg::ACC_W - faz_pkg::COEF_FRAC_BITS;

  localparam logic signed [SHIFT_W-1:0] OUT_MAX =
    SHIFT_W'((64'sd1 <<< (faz_pkg::OUT_W - 1)) - 64'sd1);
  localparam logic signed [SHIFT_W-1:0] OUT_MIN =
    SHIFT_W'(-(64'sd1 <<< (faz_pkg::OUT_W - 1)));

  logic                               res_vld_q;
  logic signed [faz_pkg::ACC_W-1:0]   res_acc_q;
  logic                               out_vld_q;
  logic signed [faz_pkg::OUT_W-1:0]   out_data_q, out_data_d;
  logic                               out_sat_q, out_sat_d;
  logic signed [faz_pkg::ACC_W-1:0]   rounded;
  logic signed [SHIFT_W-1:0]          scaled;
  logic                               load;

  // add half an LSB then floor
  assign rounded = res_acc_q + (faz_pkg::ACC_W'(1) <<< (faz_pkg::COEF_FRAC_BITS - 1));
  assign scaled  = SHIFT_W'(rounded >>> faz_pkg::COEF_FRAC_BITS);
  assign load    = res_vld_q && (!out_vld_q || out_rdy_i);

  always_comb begin
    if (scaled > OUT_MAX) begin
      out_data_d = faz_pkg::OUT_W'(OUT_MAX);
      out_sat_d  = 1'b1;
    end else if (scaled < OUT_MIN) begin
      out_data_d = faz_pkg::OUT_W'(OUT_MIN);
      out_sat_d  = 1'b1;
    end else begin
      out_data_d = faz_pkg::OUT_W'(scaled);
      out_sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pipe_i.vld) begin
        res_vld_q <= 1'b1;
      end else if (load) begin
        res_vld_q <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.vld) begin
      res_acc_q <= pipe_i.acc;
    end
    if (load) begin
      out_data_q <= out_data_d;
      out_sat_q  <= out_sat_d;
    end
  end

  assign busy_o     = res_vld_q;
  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_data_q;
  assign out_sat_o  = out_sat_q;

endmodule
